// ===== hdl/step_pkg.sv =====
// Shared types, character codes and helpers for the styled text escape parser.
// Depends on nothing; imported by styled_text_escape_parser and the testbench.
package step_pkg;

    localparam int CharWidth   = 16;
    localparam int ColorWidth  = 32;
    localparam int StyleWidth  = 4;
    localparam int DigitWidth  = 4;
    localparam int HexDigits   = 8;
    localparam int QueueDepth  = 4;
    localparam int QueuePtrW   = $clog2(QueueDepth);
    localparam int QueueCntW   = $clog2(QueueDepth + 1);

    localparam logic [ColorWidth-1:0] DefaultColor = '1;

    localparam logic [CharWidth-1:0] ChBackslash = 16'h005c;
    localparam logic [CharWidth-1:0] ChHash      = 16'h0023;
    localparam logic [CharWidth-1:0] ChDot       = 16'h002e;
    localparam logic [CharWidth-1:0] ChFontUp    = 16'h0046;
    localparam logic [CharWidth-1:0] ChFontLo    = 16'h0066;
    localparam logic [CharWidth-1:0] ChStrikeLo  = 16'h0073;
    localparam logic [CharWidth-1:0] ChStrikeUp  = 16'h0053;
    localparam logic [CharWidth-1:0] ChStrikeSym = 16'h002d;
    localparam logic [CharWidth-1:0] ChUnderLo   = 16'h0075;
    localparam logic [CharWidth-1:0] ChUnderUp   = 16'h0055;
    localparam logic [CharWidth-1:0] ChUnderSym  = 16'h005f;
    localparam logic [CharWidth-1:0] ChItalicLo  = 16'h0069;
    localparam logic [CharWidth-1:0] ChItalicUp  = 16'h0049;
    localparam logic [CharWidth-1:0] ChItalicSym = 16'h002f;
    localparam logic [CharWidth-1:0] ChBoldLo    = 16'h0062;
    localparam logic [CharWidth-1:0] ChBoldUp    = 16'h0042;
    localparam logic [CharWidth-1:0] ChBoldSym   = 16'h003d;
    localparam logic [CharWidth-1:0] ChResetLo   = 16'h0072;
    localparam logic [CharWidth-1:0] ChResetUp   = 16'h0052;

    localparam int StyleBold      = 0;
    localparam int StyleItalic    = 1;
    localparam int StyleUnderline = 2;
    localparam int StyleStrike    = 3;

    typedef struct packed {
        logic [ColorWidth-1:0] fore;
        logic                  fore_default;
        logic [ColorWidth-1:0] back;
        logic                  back_default;
        logic [CharWidth-1:0]  font;
        logic [StyleWidth-1:0] style;
    } t_attrs;

    typedef struct packed {
        logic [CharWidth-1:0] glyph;
        t_attrs               attrs;
        logic                 last;
    } t_result;

    localparam t_attrs AttrsReset = '{
        fore:         DefaultColor,
        fore_default: 1'b1,
        back:         DefaultColor,
        back_default: 1'b1,
        font:         '0,
        style:        '0
    };

    function automatic logic [3:0] hex_value(input logic [CharWidth-1:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 16'h0030 && c <= 16'h0039) begin
            v = c[3:0];
        end else if ((c >= 16'h0061 && c <= 16'h0066) || (c >= 16'h0041 && c <= 16'h0046)) begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

// ===== hdl/styled_text_escape_parser.sv =====
// Styled text escape parser: parses markup characters and queues styled glyphs.
// A four-entry result queue paces acceptance; results are registered into it.
// Throughput: one character per cycle while o_stall is low; an unknown escape
// yields two results, drained one per cycle while i_stall is low.
// Reset (synchronous, active low): plain text mode, default attributes, empty queue.
// Depends on step_pkg.
module styled_text_escape_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [step_pkg::CharWidth-1:0] i_char_code,
    input  logic                           i_end_of_string,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [step_pkg::CharWidth-1:0] o_glyph,
    output logic [step_pkg::ColorWidth-1:0] o_fore_color,
    output logic                           o_fore_is_default,
    output logic [step_pkg::ColorWidth-1:0] o_back_color,
    output logic                           o_back_is_default,
    output logic [step_pkg::CharWidth-1:0] o_font_id,
    output logic                           o_bold,
    output logic                           o_italic,
    output logic                           o_underline,
    output logic                           o_strike,
    output logic                           o_run_last
);
    import step_pkg::*;

    typedef enum logic [2:0] {
        MODE_PLAIN,
        MODE_ESC,
        MODE_HEXF,
        MODE_HEXB,
        MODE_FONT
    } t_mode;

    t_mode                  r_mode, n_mode;
    logic [ColorWidth-1:0]  r_acc, n_acc;
    logic [DigitWidth-1:0]  r_digits, n_digits;
    t_attrs                 r_attrs, n_attrs;

    t_result                r_queue [QueueDepth];
    logic [QueuePtrW-1:0]   r_head, r_tail;
    logic [QueueCntW-1:0]   r_count, n_count;

    logic                   in_xfer, out_xfer;
    logic [1:0]             push_n;
    logic [CharWidth-1:0]   glyph0, glyph1;
    logic [ColorWidth-1:0]  acc_shift;
    logic [DigitWidth-1:0]  digits_inc;
    t_result                res0, res1;

    assign o_stall  = (r_count >= QueueCntW'(QueueDepth - 1));
    assign o_valid  = (r_count != '0);
    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = o_valid && !i_stall;

    assign acc_shift  = {r_acc[ColorWidth-5:0], hex_value(i_char_code)};
    assign digits_inc = r_digits + DigitWidth'(1);

    always_comb begin
        n_mode   = r_mode;
        n_acc    = r_acc;
        n_digits = r_digits;
        n_attrs  = r_attrs;
        push_n   = 2'd0;
        glyph0   = i_char_code;
        glyph1   = i_char_code;
        unique case (r_mode)
            MODE_ESC: begin
                n_mode = MODE_PLAIN;
                unique case (i_char_code)
                    ChBackslash: begin
                        push_n = 2'd1;
                    end
                    ChHash: begin
                        n_mode   = MODE_HEXF;
                        n_acc    = '0;
                        n_digits = '0;
                    end
                    ChDot: begin
                        n_mode   = MODE_HEXB;
                        n_acc    = '0;
                        n_digits = '0;
                    end
                    ChFontUp, ChFontLo: begin
                        n_mode = MODE_FONT;
                    end
                    ChStrikeLo, ChStrikeUp, ChStrikeSym: begin
                        n_attrs.style[StyleStrike] = 1'b1;
                    end
                    ChUnderLo, ChUnderUp, ChUnderSym: begin
                        n_attrs.style[StyleUnderline] = 1'b1;
                    end
                    ChItalicLo, ChItalicUp, ChItalicSym: begin
                        n_attrs.style[StyleItalic] = 1'b1;
                    end
                    ChBoldLo, ChBoldUp, ChBoldSym: begin
                        n_attrs.style[StyleBold] = 1'b1;
                    end
                    ChResetLo, ChResetUp: begin
                        n_attrs = AttrsReset;
                    end
                    default: begin
                        push_n = 2'd2;
                        glyph0 = ChBackslash;
                    end
                endcase
            end
            MODE_HEXF, MODE_HEXB: begin
                n_acc    = acc_shift;
                n_digits = digits_inc;
                if (digits_inc >= DigitWidth'(HexDigits)) begin
                    if (r_mode == MODE_HEXF) begin
                        n_attrs.fore         = acc_shift;
                        n_attrs.fore_default = 1'b0;
                    end else begin
                        n_attrs.back         = acc_shift;
                        n_attrs.back_default = 1'b0;
                    end
                    n_mode   = MODE_PLAIN;
                    n_acc    = '0;
                    n_digits = '0;
                end
            end
            MODE_FONT: begin
                n_attrs.font = i_char_code;
                n_mode       = MODE_PLAIN;
            end
            MODE_PLAIN: begin
                if (i_char_code == ChBackslash && !i_end_of_string) begin
                    n_mode = MODE_ESC;
                end else begin
                    push_n = 2'd1;
                end
            end
            default: begin
                n_mode = MODE_PLAIN;
            end
        endcase
        if (i_end_of_string) begin
            n_mode   = MODE_PLAIN;
            n_acc    = '0;
            n_digits = '0;
        end
    end

    always_comb begin
        res0 = '{glyph: glyph0, attrs: r_attrs, last: (push_n == 2'd1)};
        res1 = '{glyph: glyph1, attrs: r_attrs, last: 1'b1};
        n_count = r_count + (in_xfer ? QueueCntW'(push_n) : '0)
                  - (out_xfer ? QueueCntW'(1) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_PLAIN;
            r_acc    <= '0;
            r_digits <= '0;
            r_attrs  <= AttrsReset;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (out_xfer) begin
                r_head <= r_head + QueuePtrW'(1);
            end
            if (in_xfer) begin
                r_mode   <= n_mode;
                r_acc    <= n_acc;
                r_digits <= n_digits;
                r_attrs  <= n_attrs;
                r_tail   <= r_tail + QueuePtrW'(push_n);
            end
        end
        if (in_xfer && push_n != 2'd0) begin
            r_queue[r_tail] <= res0;
        end
        if (in_xfer && push_n == 2'd2) begin
            r_queue[r_tail + QueuePtrW'(1)] <= res1;
        end
    end

    assign o_glyph           = r_queue[r_head].glyph;
    assign o_fore_color      = r_queue[r_head].attrs.fore;
    assign o_fore_is_default = r_queue[r_head].attrs.fore_default;
    assign o_back_color      = r_queue[r_head].attrs.back;
    assign o_back_is_default = r_queue[r_head].attrs.back_default;
    assign o_font_id         = r_queue[r_head].attrs.font;
    assign o_bold            = r_queue[r_head].attrs.style[StyleBold];
    assign o_italic          = r_queue[r_head].attrs.style[StyleItalic];
    assign o_underline       = r_queue[r_head].attrs.style[StyleUnderline];
    assign o_strike          = r_queue[r_head].attrs.style[StyleStrike];
    assign o_run_last        = r_queue[r_head].last;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QueueCntW'(QueueDepth))
        else $error("result queue overflow");

    a_digits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digits < DigitWidth'(HexDigits))
        else $error("hex digit count out of range");

    a_string_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_end_of_string) |=> (r_mode == MODE_PLAIN && r_digits == '0))
        else $error("parser not back in plain text after end of string");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for styled_text_escape_parser: directed markup table, then
// random escape sequences, checked by an in-bench parser with random idle and varied stall.
// Depends on step_pkg and styled_text_escape_parser.
module testbench;
    import step_pkg::*;

    typedef enum logic [2:0] {
        PM_TEXT, PM_ESCAPE, PM_FORE_HEX, PM_BACK_HEX, PM_FONT
    } t_parse_mode;

    typedef enum logic [1:0] {
        SP_NONE, SP_RANDOM, SP_PERIODIC, SP_RUNS
    } t_stall_pattern;

    typedef struct {
        logic [CharWidth-1:0] chr;
        logic                 eos;
        logic                 typed;
        logic [CharWidth-1:0] want_glyph;
        t_attrs               want_attrs;
    } t_char_row;

    localparam int RandomChars = 1950;
    localparam int MaxReports  = 10;
    localparam string HexChars = "0123456789abcdefABCDEF";

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [CharWidth-1:0]  i_char_code = '0;
    logic                  i_end_of_string = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [CharWidth-1:0]  o_glyph;
    logic [ColorWidth-1:0] o_fore_color;
    logic                  o_fore_is_default;
    logic [ColorWidth-1:0] o_back_color;
    logic                  o_back_is_default;
    logic [CharWidth-1:0]  o_font_id;
    logic                  o_bold;
    logic                  o_italic;
    logic                  o_underline;
    logic                  o_strike;
    logic                  o_run_last;

    styled_text_escape_parser uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_char_code       (i_char_code),
        .i_end_of_string   (i_end_of_string),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_glyph           (o_glyph),
        .o_fore_color      (o_fore_color),
        .o_fore_is_default (o_fore_is_default),
        .o_back_color      (o_back_color),
        .o_back_is_default (o_back_is_default),
        .o_font_id         (o_font_id),
        .o_bold            (o_bold),
        .o_italic          (o_italic),
        .o_underline       (o_underline),
        .o_strike          (o_strike),
        .o_run_last        (o_run_last)
    );

    always #4 i_clk = ~i_clk;

    t_char_row directed_tbl [$];
    t_char_row stim [$];
    t_result   pending_glyphs [$];

    t_parse_mode           pm;
    logic [ColorWidth-1:0] hex_acc;
    logic [DigitWidth-1:0] hex_cnt;
    t_attrs                attrs;
    t_result               step_out [2];
    int                    step_n;

    int      send_idx = 0;
    int      burst_left = 0;
    int      gap_left = 0;
    int      k;
    int      mismatches = 0;
    int      glyphs_checked = 0;
    int      pair_steps = 0;
    int      strings_ended = 0;
    int      n_directed = 0;
    int      stall_hold = 0;
    logic    stall_run_val = 1'b0;
    logic    draining = 1'b0;
    logic [31:0] stall_cycle = '0;
    t_result got;
    t_result want;

    function automatic t_char_row row(input logic [CharWidth-1:0] chr, input logic eos,
                                      input logic typed, input logic [CharWidth-1:0] glyph);
        t_char_row r;
        r.chr = chr;
        r.eos = eos;
        r.typed = typed;
        r.want_glyph = glyph;
        r.want_attrs = AttrsReset;
        return r;
    endfunction

    function automatic logic [3:0] nibble_of(input logic [CharWidth-1:0] c);
        if (c >= 16'h0030 && c <= 16'h0039) return 4'(c - 16'h0030);
        if (c >= 16'h0061 && c <= 16'h0066) return 4'(c - 16'h0061 + 16'd10);
        if (c >= 16'h0041 && c <= 16'h0046) return 4'(c - 16'h0041 + 16'd10);
        return 4'd0;
    endfunction

    function automatic t_result styled(input logic [CharWidth-1:0] ch);
        t_result r;
        r.glyph = ch;
        r.attrs = attrs;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic string fmt_result(input t_result r);
        return $sformatf("glyph=%h fore=%h/%b back=%h/%b font=%h style=%b last=%b",
                         r.glyph, r.attrs.fore, r.attrs.fore_default, r.attrs.back,
                         r.attrs.back_default, r.attrs.font, r.attrs.style, r.last);
    endfunction

    task parse_char(input logic [CharWidth-1:0] c, input logic eos);
        step_n = 0;
        case (pm)
            PM_ESCAPE: begin
                pm = PM_TEXT;
                case (c)
                    ChBackslash: begin
                        step_out[step_n] = styled(ChBackslash);
                        step_n++;
                    end
                    ChHash: begin
                        pm = PM_FORE_HEX;
                        hex_acc = '0;
                        hex_cnt = '0;
                    end
                    ChDot: begin
                        pm = PM_BACK_HEX;
                        hex_acc = '0;
                        hex_cnt = '0;
                    end
                    ChFontUp, ChFontLo: pm = PM_FONT;
                    ChStrikeLo, ChStrikeUp, ChStrikeSym: attrs.style[StyleStrike] = 1'b1;
                    ChUnderLo, ChUnderUp, ChUnderSym: attrs.style[StyleUnderline] = 1'b1;
                    ChItalicLo, ChItalicUp, ChItalicSym: attrs.style[StyleItalic] = 1'b1;
                    ChBoldLo, ChBoldUp, ChBoldSym: attrs.style[StyleBold] = 1'b1;
                    ChResetLo, ChResetUp: attrs = AttrsReset;
                    default: begin
                        step_out[0] = styled(ChBackslash);
                        step_out[1] = styled(c);
                        step_n = 2;
                    end
                endcase
            end
            PM_FORE_HEX, PM_BACK_HEX: begin
                hex_acc = {hex_acc[ColorWidth-5:0], nibble_of(c)};
                hex_cnt = hex_cnt + 4'd1;
                if (hex_cnt >= 4'(HexDigits)) begin
                    if (pm == PM_FORE_HEX) begin
                        attrs.fore = hex_acc;
                        attrs.fore_default = 1'b0;
                    end else begin
                        attrs.back = hex_acc;
                        attrs.back_default = 1'b0;
                    end
                    pm = PM_TEXT;
                    hex_acc = '0;
                    hex_cnt = '0;
                end
            end
            PM_FONT: begin
                attrs.font = c;
                pm = PM_TEXT;
            end
            default: begin
                if (c == ChBackslash) begin
                    if (eos) begin
                        step_out[0] = styled(ChBackslash);
                        step_n = 1;
                    end else begin
                        pm = PM_ESCAPE;
                    end
                end else begin
                    step_out[0] = styled(c);
                    step_n = 1;
                end
            end
        endcase
        if (eos) begin
            pm = PM_TEXT;
            hex_acc = '0;
            hex_cnt = '0;
        end
        if (step_n > 0) step_out[step_n-1].last = 1'b1;
    endtask

    task report_mismatch(input string what, input t_result exp_r, input t_result act_r);
        mismatches++;
        if (mismatches <= MaxReports) begin
            $display("%0t: %s", $time, what);
            $display("  expected %s", fmt_result(exp_r));
            $display("  actual   %s", fmt_result(act_r));
        end
    endtask

    task push_char(input logic [CharWidth-1:0] c, input logic force_eos);
        stim.insert(stim.size(), row(c, force_eos || ($urandom_range(0, 15) == 0), 1'b0, '0));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got.glyph = o_glyph;
                got.attrs.fore = o_fore_color;
                got.attrs.fore_default = o_fore_is_default;
                got.attrs.back = o_back_color;
                got.attrs.back_default = o_back_is_default;
                got.attrs.font = o_font_id;
                got.attrs.style = {o_strike, o_underline, o_italic, o_bold};
                got.last = o_run_last;
                if (pending_glyphs.size() == 0) begin
                    report_mismatch("glyph with no expectation", '0, got);
                end else begin
                    want = pending_glyphs.pop_front();
                    glyphs_checked++;
                    if (got !== want) report_mismatch("glyph mismatch", want, got);
                end
            end

            if (i_valid && !o_stall) begin
                parse_char(i_char_code, i_end_of_string);
                if (step_n == 2) pair_steps++;
                if (i_end_of_string) strings_ended++;
                if (stim[send_idx].typed) begin
                    want.glyph = stim[send_idx].want_glyph;
                    want.attrs = stim[send_idx].want_attrs;
                    want.last = 1'b1;
                    pending_glyphs.insert(pending_glyphs.size(), want);
                end else begin
                    for (k = 0; k < step_n; k++) begin
                        pending_glyphs.insert(pending_glyphs.size(), step_out[k]);
                    end
                end
                send_idx++;
            end

            if (!i_valid || !o_stall) begin
                if (send_idx < stim.size() && gap_left == 0) begin
                    i_valid <= 1'b1;
                    i_char_code <= stim[send_idx].chr;
                    i_end_of_string <= stim[send_idx].eos;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 60);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end
            end

            stall_cycle <= stall_cycle + 1;
            if (draining) begin
                i_stall <= 1'b0;
            end else begin
                case (t_stall_pattern'(stall_cycle[9:8]))
                    SP_NONE:     i_stall <= 1'b0;
                    SP_RANDOM:   i_stall <= ($urandom_range(0, 2) == 0);
                    SP_PERIODIC: i_stall <= ((stall_cycle % 5) < 2);
                    default: begin
                        if (stall_hold == 0) begin
                            stall_run_val = ~stall_run_val;
                            stall_hold = $urandom_range(1, 12);
                        end else begin
                            stall_hold--;
                        end
                        i_stall <= stall_run_val;
                    end
                endcase
            end
        end
    end

    initial begin
        int kind;
        int j;
        logic [CharWidth-1:0] c;
        logic [CharWidth-1:0] style_keys [12];

        pm = PM_TEXT;
        hex_acc = '0;
        hex_cnt = '0;
        attrs = AttrsReset;
        style_keys = '{ChStrikeLo, ChStrikeUp, ChStrikeSym, ChUnderLo, ChUnderUp, ChUnderSym,
                       ChItalicLo, ChItalicUp, ChItalicSym, ChBoldLo, ChBoldUp, ChBoldSym};

        directed_tbl = '{
            row(16'h0041, 1'b0, 1'b1, 16'h0041),
            row(ChBackslash, 1'b0, 1'b0, '0),
            row(ChBoldSym, 1'b0, 1'b0, '0),
            row(ChBackslash, 1'b0, 1'b0, '0),
            row(ChHash, 1'b0, 1'b0, '0),
            row(16'h005a, 1'b0, 1'b0, '0),
            row(16'h0066, 1'b0, 1'b0, '0),
            row(16'h0030, 1'b0, 1'b0, '0),
            row(16'h0041, 1'b0, 1'b0, '0),
            row(16'h0039, 1'b0, 1'b0, '0),
            row(16'h0061, 1'b0, 1'b0, '0),
            row(16'h0046, 1'b0, 1'b0, '0),
            row(16'h0030, 1'b0, 1'b0, '0),
            row(ChBackslash, 1'b0, 1'b0, '0),
            row(ChDot, 1'b0, 1'b0, '0),
            row(16'h0031, 1'b0, 1'b0, '0),
            row(16'h0032, 1'b1, 1'b0, '0),
            row(ChBackslash, 1'b0, 1'b0, '0),
            row(ChFontLo, 1'b0, 1'b0, '0),
            row(16'hffff, 1'b0, 1'b0, '0),
            row(ChBackslash, 1'b0, 1'b0, '0),
            row(ChBackslash, 1'b0, 1'b0, '0),
            row(ChBackslash, 1'b0, 1'b0, '0),
            row(16'h0071, 1'b0, 1'b0, '0),
            row(ChBackslash, 1'b1, 1'b0, '0),
            row(ChBackslash, 1'b0, 1'b0, '0),
            row(ChResetUp, 1'b0, 1'b0, '0),
            row(16'h0000, 1'b0, 1'b1, 16'h0000),
            row(ChBackslash, 1'b0, 1'b0, '0),
            row(ChFontUp, 1'b1, 1'b0, '0)
        };
        foreach (directed_tbl[i]) stim.insert(stim.size(), directed_tbl[i]);
        n_directed = stim.size();

        while (stim.size() < n_directed + RandomChars) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                if ($urandom_range(0, 3) == 0) begin
                    c = 16'($urandom);
                end else begin
                    c = 16'($urandom_range(16'h0020, 16'h007e));
                    if (c == ChBackslash) c = 16'h0078;
                end
                push_char(c, 1'b0);
            end else if (kind < 52) begin
                push_char(ChBackslash, 1'b0);
                push_char($urandom_range(0, 1) ? ChHash : ChDot, 1'b0);
                for (j = 0; j < HexDigits; j++) begin
                    if ($urandom_range(0, 19) < 17) c = {8'h00, HexChars[$urandom_range(0, 21)]};
                    else c = 16'($urandom);
                    push_char(c, 1'b0);
                end
            end else if (kind < 60) begin
                push_char(ChBackslash, 1'b0);
                push_char($urandom_range(0, 1) ? ChFontUp : ChFontLo, 1'b0);
                push_char(16'($urandom), 1'b0);
            end else if (kind < 75) begin
                push_char(ChBackslash, 1'b0);
                push_char(style_keys[$urandom_range(0, 11)], 1'b0);
            end else if (kind < 80) begin
                push_char(ChBackslash, 1'b0);
                push_char($urandom_range(0, 1) ? ChResetUp : ChResetLo, 1'b0);
            end else if (kind < 84) begin
                push_char(ChBackslash, 1'b0);
                push_char(ChBackslash, 1'b0);
            end else if (kind < 93) begin
                push_char(ChBackslash, 1'b0);
                if ($urandom_range(0, 1)) c = 16'($urandom);
                else c = 16'($urandom_range(16'h0020, 16'h007e));
                push_char(c, 1'b0);
            end else begin
                push_char(ChBackslash, 1'b1);
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (send_idx < stim.size() || pending_glyphs.size() != 0) @(posedge i_clk);
        draining <= 1'b1;
        repeat (16) @(posedge i_clk);
        if (pending_glyphs.size() != 0) begin
            mismatches += pending_glyphs.size();
            $display("%0d expected glyphs never arrived", pending_glyphs.size());
        end

        $display("Sent %0d characters (%0d directed) over %0d strings;", send_idx, n_directed,
                 strings_ended);
        $display("checked %0d glyphs, %0d from two-glyph escapes; %0d mismatches.",
                 glyphs_checked, 2 * pair_steps, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #3_200_000;
        $display("Verification failed");
        $finish;
    end

endmodule
